[hdl/dsdc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dsdc_pkg: shared types and constants of the date / serial day converter
// Holds the field widths, the opcode and state encodings, the interfaces
// between the sequencer and its helper units, and the month length table.
// ----------------------------------------------------------------------------
package dsdc_pkg;

  // Field widths of the words on the two channels.
  localparam int OPC_W  = 3;
  localparam int YEAR_W = 14;
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;
  localparam int SER_W  = 23;

  // Width of the internal day index (days since 0001-01-01, signed).
  localparam int IW  = 26;
  // Width of the year counter; covers every allowed maximum year.
  localparam int YCW = 16;

  localparam int DAYS_YEAR = 365;
  localparam int DAYS_LEAP = 366;

  localparam logic [MON_W-1:0] MON_JAN = 4'd1;
  localparam logic [MON_W-1:0] MON_FEB = 4'd2;
  localparam logic [MON_W-1:0] MON_APR = 4'd4;
  localparam logic [MON_W-1:0] MON_JUN = 4'd6;
  localparam logic [MON_W-1:0] MON_SEP = 4'd9;
  localparam logic [MON_W-1:0] MON_NOV = 4'd11;
  localparam logic [MON_W-1:0] MON_DEC = 4'd12;

  typedef enum logic [OPC_W-1:0] {
    OP_TO_SERIAL   = 3'd0,
    OP_FROM_SERIAL = 3'd1,
    OP_NEXT_DAY    = 3'd2,
    OP_PREV_DAY    = 3'd3,
    OP_ADD_OFFSET  = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_YUP,
    S_MUP,
    S_APPLY,
    S_RANGE,
    S_YDN,
    S_MDN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [IW-1:0] a;
    logic signed [IW-1:0] b;
    logic                 sub;
  } alu_req_t;

  typedef struct packed {
    logic signed [IW-1:0] sum;
    logic                 neg;
  } alu_rsp_t;

  typedef struct packed {
    logic clear;
    logic step;
  } year_ctl_t;

  // Number of days in month m; leap selects the long February.
  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      MON_FEB:                          len = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      default:                          len = 5'd31;
    endcase
    return len;
  endfunction

  // Day index of January 1st of year y; evaluated at elaboration only.
  function automatic int year_start_idx(input int y);
    int p;
    p = y - 1;
    return p * 365 + p / 4 - p / 100 + p / 400;
  endfunction

endpackage
`default_nettype wire

[hdl/date_serial_day_converter_top.sv]
// to_serial walks up from year 1 to the input date; from_serial walks down
// from its day index to the result date. next_day, prev_day and add_offset
// walk both ways. The year walk runs through the shared adder, one year per
// cycle; the block works on one word at a time.
// Synchronous reset empties the sequencer and the output register.
`default_nettype none
// ----------------------------------------------------------------------------
// date_serial_day_converter_top: Gregorian date / serial day number unit
// Converts dates to signed serial day numbers and back, steps a date by one
// day or by a signed offset, and flags invalid or out-of-range words.
// ----------------------------------------------------------------------------
module date_serial_day_converter_top
  import dsdc_pkg::*;
#(
  parameter int BASE_YEAR = 1900,
  parameter int MAX_YEAR  = 9999
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OPC_W-1:0]        opcode,
  input  logic [YEAR_W-1:0]       in_year,
  input  logic [MON_W-1:0]        in_month,
  input  logic [DAY_W-1:0]        in_day,
  input  logic signed [SER_W-1:0] in_serial,
  input  logic signed [SER_W-1:0] day_offset,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [YEAR_W-1:0]       out_year,
  output logic [MON_W-1:0]        out_month,
  output logic [DAY_W-1:0]        out_day,
  output logic signed [SER_W-1:0] out_serial,
  output logic                    error_flag
);

  // Day index of the serial origin (serial 1) and of the last supported day.
  localparam logic signed [IW-1:0] BASE_IDX  = IW'(year_start_idx(BASE_YEAR));
  localparam logic signed [IW-1:0] BASE_M1   = IW'(year_start_idx(BASE_YEAR) - 1);
  localparam logic signed [IW-1:0] NEG_BASE  = IW'(-year_start_idx(BASE_YEAR));
  localparam logic signed [IW-1:0] ONE_MBASE = IW'(1 - year_start_idx(BASE_YEAR));
  localparam logic signed [IW-1:0] LAST_IDX  = IW'(year_start_idx(MAX_YEAR + 1) - 1);

  state_t state, state_next;

  // Captured input word.
  logic [OPC_W-1:0]        op_r;
  logic [YEAR_W-1:0]       yr_r;
  logic [MON_W-1:0]        mo_r;
  logic [DAY_W-1:0]        dy_r;
  logic signed [SER_W-1:0] ser_r;
  logic signed [SER_W-1:0] off_r;

  // Working registers: the day index accumulator, month counter, error.
  logic signed [IW-1:0] acc, acc_next;
  logic [MON_W-1:0]     mcnt, mcnt_next;
  logic                 err, err_next;

  logic load_out;

  alu_req_t       alu_req;
  alu_rsp_t       alu_rsp;
  year_ctl_t      yctl;
  logic [YCW-1:0] ycnt;
  logic           leap;

  logic signed [IW-1:0] ser_ext;
  logic signed [IW-1:0] off_ext;
  logic [DAY_W-1:0]     cur_mlen;
  logic signed [IW-1:0] cur_ylen;

  dsdc_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  dsdc_year u_year (
    .clk  (clk),
    .ctl  (yctl),
    .year (ycnt),
    .leap (leap)
  );

  // The block takes a new word only when the sequencer is idle; a finished
  // result waiting in the output register does not hold the input side.
  assign in_stall = (state != S_IDLE);

  assign ser_ext  = {{(IW-SER_W){ser_r[SER_W-1]}}, ser_r};
  assign off_ext  = {{(IW-SER_W){off_r[SER_W-1]}}, off_r};
  assign cur_mlen = month_len(mcnt, leap);
  assign cur_ylen = leap ? IW'(DAYS_LEAP) : IW'(DAYS_YEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    acc  <= acc_next;
    mcnt <= mcnt_next;
    err  <= err_next;
    if (in_valid && !in_stall) begin
      op_r  <= opcode;
      yr_r  <= in_year;
      mo_r  <= in_month;
      dy_r  <= in_day;
      ser_r <= in_serial;
      off_r <= day_offset;
    end
  end

  // Sequencer. The forward walk sums year and month lengths from 0001-01-01
  // up to the input date. The backward walk subtracts them from a day index
  // until the remainder falls inside one month. Both use the same adder.
  always_comb begin
    state_next  = state;
    acc_next    = acc;
    mcnt_next   = mcnt;
    err_next    = err;
    yctl        = '0;
    alu_req.a   = acc;
    alu_req.b   = '0;
    alu_req.sub = 1'b0;
    load_out    = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CHECK;
        end
      end

      S_CHECK: begin
        err_next = 1'b0;
        if (op_r > OP_ADD_OFFSET) begin
          err_next   = 1'b1;
          state_next = S_DONE;
        end else if (op_r == OP_FROM_SERIAL) begin
          if (ser_r == '0) begin
            err_next   = 1'b1;
            state_next = S_DONE;
          end else begin
            // Positive serials skip the missing serial zero.
            alu_req.a  = ser_ext;
            alu_req.b  = ser_r[SER_W-1] ? BASE_IDX : BASE_M1;
            acc_next   = alu_rsp.sum;
            state_next = S_RANGE;
          end
        end else if ((yr_r == '0) || (int'(yr_r) > MAX_YEAR) || (mo_r == '0) ||
                     (mo_r > MON_DEC) || (dy_r == '0)) begin
          err_next   = 1'b1;
          state_next = S_DONE;
        end else begin
          acc_next   = '0;
          yctl.clear = 1'b1;
          state_next = S_YUP;
        end
      end

      S_YUP: begin
        if (ycnt == YCW'(yr_r)) begin
          // The leap flag now belongs to the input year: finish the check.
          if (dy_r > month_len(mo_r, leap)) begin
            err_next   = 1'b1;
            state_next = S_DONE;
          end else begin
            mcnt_next  = MON_JAN;
            state_next = S_MUP;
          end
        end else begin
          alu_req.b = cur_ylen;
          acc_next  = alu_rsp.sum;
          yctl.step = 1'b1;
        end
      end

      S_MUP: begin
        if (mcnt == mo_r) begin
          alu_req.b  = {{(IW-DAY_W){1'b0}}, DAY_W'(dy_r - 1'b1)};
          acc_next   = alu_rsp.sum;
          state_next = S_APPLY;
        end else begin
          alu_req.b = {{(IW-DAY_W){1'b0}}, cur_mlen};
          acc_next  = alu_rsp.sum;
          mcnt_next = mcnt + 1'b1;
        end
      end

      S_APPLY: begin
        unique case (op_r)
          OP_TO_SERIAL: begin
            // Dates on or after the origin count from 1, earlier ones from -1.
            alu_req.b  = (acc >= BASE_IDX) ? ONE_MBASE : NEG_BASE;
            acc_next   = alu_rsp.sum;
            state_next = S_DONE;
          end
          OP_NEXT_DAY: begin
            alu_req.b  = {{(IW-1){1'b0}}, 1'b1};
            acc_next   = alu_rsp.sum;
            state_next = S_RANGE;
          end
          OP_PREV_DAY: begin
            alu_req.b  = {IW{1'b1}};
            acc_next   = alu_rsp.sum;
            state_next = S_RANGE;
          end
          OP_ADD_OFFSET: begin
            alu_req.b  = off_ext;
            acc_next   = alu_rsp.sum;
            state_next = S_RANGE;
          end
          default: begin
            err_next   = 1'b1;
            state_next = S_DONE;
          end
        endcase
      end

      S_RANGE: begin
        if (acc[IW-1] || (acc > LAST_IDX)) begin
          err_next   = 1'b1;
          state_next = S_DONE;
        end else begin
          yctl.clear = 1'b1;
          state_next = S_YDN;
        end
      end

      S_YDN: begin
        alu_req.sub = 1'b1;
        alu_req.b   = cur_ylen;
        if (!alu_rsp.neg) begin
          acc_next  = alu_rsp.sum;
          yctl.step = 1'b1;
        end else begin
          mcnt_next  = MON_JAN;
          state_next = S_MDN;
        end
      end

      S_MDN: begin
        alu_req.sub = 1'b1;
        alu_req.b   = {{(IW-DAY_W){1'b0}}, cur_mlen};
        if ((mcnt != MON_DEC) && !alu_rsp.neg) begin
          acc_next  = alu_rsp.sum;
          mcnt_next = mcnt + 1'b1;
        end else begin
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output register. A failed word reports zeros beside the error flag;
  // to_serial echoes the date, the other opcodes report the walked date.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      error_flag <= err;
      if (err) begin
        out_year   <= '0;
        out_month  <= '0;
        out_day    <= '0;
        out_serial <= '0;
      end else if (op_r == OP_TO_SERIAL) begin
        out_year   <= yr_r;
        out_month  <= mo_r;
        out_day    <= dy_r;
        out_serial <= acc[SER_W-1:0];
      end else begin
        out_year   <= ycnt[YEAR_W-1:0];
        out_month  <= mcnt;
        out_day    <= DAY_W'(acc[DAY_W-1:0] + 1'b1);
        out_serial <= '0;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/dsdc_alu.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dsdc_alu: shared adder of the converter
// One signed add or subtract on the day index, with the sign of the result
// used as the compare outcome by the walking states.
// ----------------------------------------------------------------------------
module dsdc_alu
  import dsdc_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic signed [IW-1:0] b_eff;

  assign b_eff   = req.sub ? ~req.b : req.b;
  assign rsp.sum = req.a + b_eff + {{(IW-1){1'b0}}, req.sub};
  assign rsp.neg = rsp.sum[IW-1];

endmodule
`default_nettype wire

[hdl/dsdc_year.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dsdc_year: year counter with leap tracking
// Counts years from 1 upward and keeps the year modulo 4, 100 and 400 in
// wrapping counters, so the leap flag needs no division.
// ----------------------------------------------------------------------------
module dsdc_year
  import dsdc_pkg::*;
(
  input  logic            clk,
  input  year_ctl_t       ctl,
  output logic [YCW-1:0]  year,
  output logic            leap
);

  localparam logic [6:0] C100_LAST = 7'd99;
  localparam logic [8:0] C400_LAST = 9'd399;

  logic [1:0] c4;
  logic [6:0] c100;
  logic [8:0] c400;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      year <= {{(YCW-1){1'b0}}, 1'b1};
      c4   <= 2'd1;
      c100 <= 7'd1;
      c400 <= 9'd1;
    end else if (ctl.step) begin
      year <= year + 1'b1;
      c4   <= c4 + 1'b1;
      c100 <= (c100 == C100_LAST) ? 7'd0 : c100 + 1'b1;
      c400 <= (c400 == C400_LAST) ? 9'd0 : c400 + 1'b1;
    end
  end

  assign leap = (c400 == 9'd0) || ((c100 != 7'd0) && (c4 == 2'd0));

endmodule
`default_nettype wire

[hdl/dsdc_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dsdc_checker: port-level checks of the converter
// Watches the handshakes and the result words seen at the top level ports.
// ----------------------------------------------------------------------------
module dsdc_checker
  import dsdc_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic [YEAR_W-1:0]       out_year,
  input wire logic [MON_W-1:0]        out_month,
  input wire logic [DAY_W-1:0]        out_day,
  input wire logic signed [SER_W-1:0] out_serial,
  input wire logic                    error_flag
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_year) && $stable(out_month) &&
      $stable(out_day) && $stable(out_serial) && $stable(error_flag))
    else $error("result word changed while stalled");

  // Each accepted word keeps the input side closed while it is worked on.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again with no cycle of work");

  // An error word carries only zeros beside the flag.
  a_error_zeros: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_flag |-> out_year == '0 && out_month == '0 &&
      out_day == '0 && out_serial == '0)
    else $error("error word with nonzero fields");

  // A good word carries nonzero fields and a month no later than December.
  a_date_sane: assert property (@(posedge clk) disable iff (rst)
    out_valid && !error_flag |-> out_year != '0 && out_month != '0 &&
      out_month <= MON_DEC && out_day != '0)
    else $error("good word with an impossible date");

endmodule

bind date_serial_day_converter_top dsdc_checker u_dsdc_checker (.*);
`default_nettype wire

[tb/date_serial_day_converter_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// date_serial_day_converter_top_test: self-checking bench for the date unit
// Sends directed and random words through the valid/stall input channel,
// predicts each result in a scoreboard and checks every result word that
// leaves the output channel, with random idle bursts on both sides.
// ----------------------------------------------------------------------------
module date_serial_day_converter_top_test;
  import dsdc_pkg::*;

  // The bench runs the block with its default calendar limits.
  localparam int BASE_YEAR = 1900;
  localparam int MAX_YEAR  = 9999;

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_WORDS = 75;
  // The timeout allows for every word walking all the years both ways, plus
  // idle bursts, several times over.
  localparam int LIMIT_CYCLES = 10_000_000;
  // Cycles to keep watching after the last expected result has arrived.
  localparam int TAIL_CYCLES  = 200;

  // Opcodes that the block does not implement; they must raise the error flag.
  localparam logic [OPC_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OPC_W-1:0] OP_UNUSED_HI = 3'd7;

  // One word on the input channel.
  typedef struct packed {
    logic [OPC_W-1:0]        opcode;
    logic [YEAR_W-1:0]       year;
    logic [MON_W-1:0]        month;
    logic [DAY_W-1:0]        day;
    logic signed [SER_W-1:0] serial;
    logic signed [SER_W-1:0] offset;
  } date_word_t;

  // One word on the output channel.
  typedef struct packed {
    logic [YEAR_W-1:0]       year;
    logic [MON_W-1:0]        month;
    logic [DAY_W-1:0]        day;
    logic signed [SER_W-1:0] serial;
    logic                    error;
  } date_result_t;

  // The scoreboard converts every accepted input word into the result word
  // that the block must produce, and holds those in arrival order. The block
  // keeps no state between words, so each prediction stands on its own.
  class date_scoreboard;
    date_result_t expected_dates[$];
    int mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Gregorian rule: every fourth year, except centuries not divisible by 400.
    function bit is_leap(longint y);
      return (y % 400 == 0) || (y % 100 != 0 && y % 4 == 0);
    endfunction

    function longint days_in_month(longint y, longint m);
      case (m)
        MON_FEB:                            return is_leap(y) ? 29 : 28;
        MON_APR, MON_JUN, MON_SEP, MON_NOV: return 30;
        default:                            return 31;
      endcase
    endfunction

    function bit date_valid(longint y, longint m, longint d);
      if (y < 1 || y > MAX_YEAR || m < MON_JAN || m > MON_DEC || d < 1)
        return 1'b0;
      return d <= days_in_month(y, m);
    endfunction

    // Days elapsed since 0001-01-01 for a valid date.
    function longint day_number(longint y, longint m, longint d);
      longint p;
      longint n;
      p = y - 1;
      n = p * 365 + p / 4 - p / 100 + p / 400;
      for (longint k = MON_JAN; k < m; k++)
        n += days_in_month(y, k);
      return n + d - 1;
    endfunction

    // Inverse of day_number: peel off 400-, 100-, 4- and 1-year cycles, then
    // walk the months of the final year.
    function date_result_t date_of_number(longint n);
      date_result_t r;
      longint q400, q100, q4, q1, rem, y, m;
      q400 = n / 146097;
      rem  = n % 146097;
      q100 = rem / 36524;
      if (q100 > 3) q100 = 3;
      rem -= q100 * 36524;
      q4  = rem / 1461;
      rem = rem % 1461;
      q1  = rem / 365;
      if (q1 > 3) q1 = 3;
      rem -= q1 * 365;
      y = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
      m = MON_JAN;
      while (m < MON_DEC && rem >= days_in_month(y, m)) begin
        rem -= days_in_month(y, m);
        m++;
      end
      r = '0;
      r.year  = YEAR_W'(y);
      r.month = MON_W'(m);
      r.day   = DAY_W'(rem + 1);
      return r;
    endfunction

    function date_result_t convert_word(date_word_t w);
      date_result_t r;
      longint ser, off, n, first_day, last_day;
      r = '0;
      ser = longint'(w.serial);
      off = longint'(w.offset);
      first_day = day_number(BASE_YEAR, MON_JAN, 1);
      last_day  = day_number(MAX_YEAR, MON_DEC, 31);
      if (w.opcode > OP_ADD_OFFSET) begin
        r.error = 1'b1;
        return r;
      end
      if (w.opcode == OP_FROM_SERIAL) begin
        // Serial numbers skip zero: 1 is the base date, -1 the day before.
        if (ser == 0) begin
          r.error = 1'b1;
          return r;
        end
        n = first_day + (ser > 0 ? ser - 1 : ser);
      end else begin
        if (!date_valid(w.year, w.month, w.day)) begin
          r.error = 1'b1;
          return r;
        end
        n = day_number(w.year, w.month, w.day);
        case (w.opcode)
          OP_TO_SERIAL: begin
            r.year   = w.year;
            r.month  = w.month;
            r.day    = w.day;
            r.serial = SER_W'((n >= first_day) ? n - first_day + 1 : n - first_day);
            return r;
          end
          OP_NEXT_DAY: n = n + 1;
          OP_PREV_DAY: n = n - 1;
          default:     n = n + off;
        endcase
      end
      if (n < 0 || n > last_day) begin
        r.error = 1'b1;
        return r;
      end
      return date_of_number(n);
    endfunction

    function void note_input(date_word_t w);
      expected_dates.push_back(convert_word(w));
    endfunction

    function void compare_field(string name, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(date_result_t got);
      date_result_t want;
      if (expected_dates.size() == 0) begin
        $display("%0t: unexpected result word, actual %0d-%0d-%0d serial %0d error %0b",
                 $time, got.year, got.month, got.day, got.serial, got.error);
        mismatches++;
        return;
      end
      want = expected_dates.pop_front();
      compare_field("out_year", want.year, got.year);
      compare_field("out_month", want.month, got.month);
      compare_field("out_day", want.day, got.day);
      compare_field("out_serial", want.serial, got.serial);
      compare_field("error_flag", want.error, got.error);
    endfunction

    function int pending();
      return expected_dates.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [OPC_W-1:0]        opcode;
  logic [YEAR_W-1:0]       in_year;
  logic [MON_W-1:0]        in_month;
  logic [DAY_W-1:0]        in_day;
  logic signed [SER_W-1:0] in_serial;
  logic signed [SER_W-1:0] day_offset;
  logic                    out_valid;
  logic                    out_stall;
  logic [YEAR_W-1:0]       out_year;
  logic [MON_W-1:0]        out_month;
  logic [DAY_W-1:0]        out_day;
  logic signed [SER_W-1:0] out_serial;
  logic                    error_flag;

  // When set, both the sender and the receiver idle in random bursts.
  logic idle_enable = 1'b1;

  date_scoreboard board = new();

  date_serial_day_converter_top #(
    .BASE_YEAR(BASE_YEAR),
    .MAX_YEAR (MAX_YEAR)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .in_year   (in_year),
    .in_month  (in_month),
    .in_day    (in_day),
    .in_serial (in_serial),
    .day_offset(day_offset),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_year  (out_year),
    .out_month (out_month),
    .out_day   (out_day),
    .out_serial(out_serial),
    .error_flag(error_flag)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Presents one word at a falling edge and holds it until the rising edge at
  // which the block takes it. Valid stays high from one word to the next
  // unless an idle burst is drawn, so it is never dropped and raised in the
  // same time step. The task returns at the falling edge after acceptance.
  task automatic send_word(input logic [OPC_W-1:0] op, input int yr, input int mo,
                           input int dy, input int ser, input int off);
    date_word_t w;
    w.opcode = op;
    w.year   = YEAR_W'(yr);
    w.month  = MON_W'(mo);
    w.day    = DAY_W'(dy);
    w.serial = SER_W'(ser);
    w.offset = SER_W'(off);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= w.opcode;
    in_year    <= w.year;
    in_month   <= w.month;
    in_day     <= w.day;
    in_serial  <= w.serial;
    day_offset <= w.offset;
    do @(posedge clk); while (in_stall);
    board.note_input(w);
    @(negedge clk);
  endtask

  // Holds the sender back until every predicted result has come out. Valid
  // drops first so the last word is not taken a second time.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  // Receiver side: out_stall changes only at falling edges. A stalled burst
  // starts now and then while idling is enabled.
  initial begin
    int hold;
    out_stall = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // A result word is taken at every rising edge with out_valid high and
  // out_stall low; the values seen here are those from before the edge.
  always @(posedge clk) begin : result_monitor
    date_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.year   = out_year;
      got.month  = out_month;
      got.day    = out_day;
      got.serial = out_serial;
      got.error  = error_flag;
      board.check_result(got);
    end
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    logic [OPC_W-1:0] op;
    int yr, mo, dy, ser, off, band;

    rst        = 1'b1;
    in_valid   = 1'b0;
    opcode     = OP_TO_SERIAL;
    in_year    = '0;
    in_month   = '0;
    in_day     = '0;
    in_serial  = '0;
    day_offset = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Directed words. Conversions around the base date, where the serial
    // jumps from -1 to 1, and at both ends of the supported years.
    send_word(OP_TO_SERIAL, 1900, 1, 1, 0, 0);
    send_word(OP_TO_SERIAL, 1899, 12, 31, 0, 0);
    send_word(OP_TO_SERIAL, 1, 1, 1, 0, 0);
    send_word(OP_TO_SERIAL, MAX_YEAR, 12, 31, 0, 0);
    send_word(OP_FROM_SERIAL, 2000, 6, 15, 1, 0);
    send_word(OP_FROM_SERIAL, 0, 0, 0, -1, 0);
    send_word(OP_FROM_SERIAL, 0, 0, 0, 0, 0);
    send_word(OP_FROM_SERIAL, 0, 0, 0, -693595, 0);
    send_word(OP_FROM_SERIAL, 0, 0, 0, -693596, 0);
    send_word(OP_FROM_SERIAL, 0, 0, 0, 2958464, 0);
    send_word(OP_FROM_SERIAL, 0, 0, 0, 2958465, 0);
    send_word(OP_FROM_SERIAL, 0, 0, 0, -4194304, 0);
    // Stepping over a non-leap century February, a year end, and off either
    // end of the calendar.
    send_word(OP_NEXT_DAY, 1900, 2, 28, 0, 0);
    send_word(OP_NEXT_DAY, 1999, 12, 31, 0, 0);
    send_word(OP_NEXT_DAY, MAX_YEAR, 12, 31, 0, 0);
    send_word(OP_PREV_DAY, 1, 1, 1, 0, 0);
    send_word(OP_PREV_DAY, 2000, 3, 1, 0, 0);
    // Offsets spanning the whole calendar, and one far past its start.
    send_word(OP_ADD_OFFSET, 1, 1, 1, 0, 3652058);
    send_word(OP_ADD_OFFSET, MAX_YEAR, 12, 31, 0, -3652058);
    send_word(OP_ADD_OFFSET, 1, 1, 1, 0, -4194304);
    // Invalid dates: zero year, month and day fields, oversized year and month
    // fields, the 29th of February in a century year, and the 31st of a 30-day month.
    send_word(OP_TO_SERIAL, 0, 5, 5, 0, 0);
    send_word(OP_NEXT_DAY, 16383, 5, 5, 0, 0);
    send_word(OP_PREV_DAY, 2000, 0, 5, 0, 0);
    send_word(OP_ADD_OFFSET, 2000, 15, 5, 0, 1);
    send_word(OP_TO_SERIAL, 2000, 5, 0, 0, 0);
    send_word(OP_TO_SERIAL, 1900, 2, 29, 0, 0);
    send_word(OP_NEXT_DAY, 2001, 4, 31, 0, 0);
    // Opcodes with no function.
    send_word(OP_UNUSED_LO, 2000, 1, 1, 1, 1);
    send_word(OP_UNUSED_HI, 2000, 1, 1, 1, 1);
    wait_for_results();

    // Random words. Latency grows with the years walked, so most dates sit
    // in the first two centuries, a quarter near the base year and the rest
    // anywhere. One word in ten carries raw, mostly invalid, date fields.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      // Idling runs only over the first forty words and stays off for the
      // rest.
      idle_enable <= !(i >= 40 && i < 55) && (i < RANDOM_WORDS - 20);
      if (i == 50) wait_for_results();

      if ($urandom_range(0, 19) == 0)
        op = OPC_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      else
        op = OPC_W'($urandom_range(OP_TO_SERIAL, OP_ADD_OFFSET));

      band = $urandom_range(0, 99);
      if (band < 60)      yr = $urandom_range(1, 200);
      else if (band < 85) yr = $urandom_range(1850, 2100);
      else                yr = $urandom_range(1, MAX_YEAR);
      mo = $urandom_range(MON_JAN, MON_DEC);
      dy = $urandom_range(1, int'(board.days_in_month(yr, mo)));
      if ($urandom_range(0, 9) == 0) begin
        yr = $urandom_range(0, (1 << YEAR_W) - 1);
        mo = $urandom_range(0, (1 << MON_W) - 1);
        dy = $urandom_range(0, (1 << DAY_W) - 1);
      end

      // Serials mostly land in early years or around the base date.
      band = $urandom_range(0, 99);
      if (band < 55)      ser = $urandom_range(0, 73000) - 693595;
      else if (band < 80) ser = $urandom_range(0, 146000) - 73000;
      else if (band < 90) ser = $urandom_range(0, 3652059) - 693595;
      else                ser = int'($urandom());

      // Offsets mostly stay near the date; a few use the full field.
      band = $urandom_range(0, 99);
      if (band < 70)      off = $urandom_range(0, 1600) - 800;
      else if (band < 85) off = $urandom_range(0, 73000) - 36500;
      else                off = int'($urandom());

      send_word(op, yr, mo, dy, ser, off);
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (board.mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
